FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the hash table unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define OAH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hash table check failed");

// Clocked implication check built on the macro above.
`define OAH_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    `OAH_ASSERT(lbl, clk, rstn, (pre) |-> (post))

`endif

FILE: hdl/oah_pkg.sv
// Package of the open-address hash table unit: codes, widths and shared types.
// Depends on nothing.
package oah_pkg;

    localparam int DEF_SLOTS       = 1024;
    localparam int DEF_PROBE_LIMIT = 64;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int FIELD_BITS = 32;   // width of key, hash and value ports
    localparam int CFG_BITS   = 11;   // width of the configuration data word
    localparam int CNT_BITS   = 11;   // entry count width
    localparam int REC_BITS   = 7;    // longest probe width
    localparam int STEP_BITS  = 8;    // probe step counter, up to 255
    localparam int DIV_BITS   = 32;   // dividend width of the remainder unit

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_GET    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] CFG_BUCKETS  = 2'd0;
    localparam logic [1:0] CFG_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_OFFSET   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

FILE: hdl/oah_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on oah_pkg.
module oah_mod import oah_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [DIV_BITS-1:0]              i_dividend,
    input  logic [$clog2(SLOTS+1)-1:0]       i_divisor,
    output t_mod_stat                        o_stat,
    output logic [$clog2(SLOTS+1)-1:0]       o_rem
);
    localparam int BW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] r_q;
    logic [BW-1:0]       r_rem, n_rem;
    logic [NW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [BW:0]         trial;

    // Shift in the next bit and subtract the divisor when it fits.
    always_comb begin
        trial = {r_rem, r_q[DIV_BITS-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = BW'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

FILE: hdl/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit with quadratic probing.
// Depends on oah_pkg, oah_mod and assert_macros.svh.
//
// Usage. A word on the input channel carries an action (insert, remove,
// search, get, clear), a key, the key's hash and a value. Every word gives
// exactly one result word: ok, the value found by get, the entry count and
// the longest insert probe since the last clear. The configuration channel
// writes bucket count, capacity and probe offset; it is always ready, and the
// user must write it only while the unit is idle; the unit does not enforce it.
// Probing. Each bucket index is reduced modulo the bucket count by one shared
// bit-serial remainder unit, and each probe reads the slot memory in state
// S_READ and compares the entry in S_CMP. An insert at capacity runs the
// bounded search first and, only if it finds the key, then the insert chain.
// Clear sweeps the valid bits of every slot.
// Only one word is worked on at a time; the input ready is high in idle.
// Reset. After reset the unit sweeps the valid memory, one slot a cycle,
// before it accepts its first word.
// Stalls. The result sits in an output register; the next word is accepted
// while it waits, and a second finished result waits in the unit until the
// receiver takes the first.
module open_address_hash_table_unit import oah_pkg::*; #(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int PROBE_LIMIT = DEF_PROBE_LIMIT,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_action,
    input  logic [FIELD_BITS-1:0] i_key,
    input  logic [FIELD_BITS-1:0] i_key_hash,
    input  logic [FIELD_BITS-1:0] i_new_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [FIELD_BITS-1:0] o_found_value,
    output logic [CNT_BITS-1:0]   o_entry_count,
    output logic [REC_BITS-1:0]   o_longest_probe,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data
);
    `include "assert_macros.svh"

    localparam int SW = $clog2(SLOTS);
    localparam int BW = $clog2(SLOTS + 1);
    localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int QW = 2 * STEP_BITS;

    typedef enum logic [6:0] {
        S_SWEEP = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_STEP  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Slot memories.
    logic [KW-1:0] key_mem   [SLOTS];
    logic [VW-1:0] value_mem [SLOTS];
    logic          valid_mem [SLOTS];

    t_state              r_state, n_state;
    logic [2:0]          r_act, n_act;
    logic [KW-1:0]       r_key, n_key;
    logic [VW-1:0]       r_val, n_val;
    logic [SW-1:0]       r_home, n_home, r_slot, n_slot, r_sweep, n_sweep;
    logic [STEP_BITS-1:0] r_c, n_c;
    logic [QW-1:0]       r_sq, n_sq;
    logic                r_ins, n_ins;
    logic [CNT_BITS-1:0] r_held, n_held;
    logic [REC_BITS-1:0] r_rec, n_rec;
    logic                r_ok, n_ok;
    logic [VW-1:0]       r_found, n_found;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok;
    logic [VW-1:0]       r_out_found;
    logic [CNT_BITS-1:0] r_out_cnt;
    logic [REC_BITS-1:0] r_out_rec;
    logic                out_load;
    logic [CFG_BITS-1:0] r_bucket, r_cap;
    logic [3:0]          r_offset;

    logic                r_rd_valid;
    logic [KW-1:0]       r_rd_key;
    logic [VW-1:0]       r_rd_val;

    logic                we_valid, we_key, we_val, wd_valid;
    logic [SW-1:0]       w_addr;

    logic                mod_start;
    logic [DIV_BITS-1:0] mod_div;
    t_mod_stat           mod_stat;
    logic [BW-1:0]       mod_rem, eff_b;

    logic                in_acc, key_eq, within_rec;

    // Bucket count as used: clamped to the range 2 .. SLOTS.
    always_comb begin
        if (r_bucket < CFG_BITS'(2)) begin
            eff_b = BW'(2);
        end else if (32'(r_bucket) > 32'(SLOTS)) begin
            eff_b = BW'(SLOTS);
        end else begin
            eff_b = BW'(r_bucket);
        end
    end

    oah_mod #(.SLOTS(SLOTS)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_div),
        .i_divisor  (eff_b),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc = i_in_valid && o_in_ready;
    assign key_eq = (r_rd_key == r_key);
    assign within_rec = (r_c <= STEP_BITS'(r_rec));

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_key   = r_key;
        n_val   = r_val;
        n_home  = r_home;
        n_slot  = r_slot;
        n_sweep = r_sweep;
        n_c     = r_c;
        n_sq    = r_sq;
        n_ins   = r_ins;
        n_held  = r_held;
        n_rec   = r_rec;
        n_ok    = r_ok;
        n_found = r_found;
        out_load = 1'b0;
        we_valid = 1'b0;
        we_key   = 1'b0;
        we_val   = 1'b0;
        wd_valid = 1'b0;
        w_addr   = r_slot;
        mod_start = 1'b0;
        mod_div   = DIV_BITS'(r_slot) + DIV_BITS'(r_sq + QW'({r_c, 1'b1}))
                    + DIV_BITS'(r_offset);

        unique case (r_state)
            S_SWEEP: begin
                we_valid = 1'b1;
                w_addr   = r_sweep;
                n_sweep  = r_sweep + 1'b1;
                if (r_sweep == SW'(SLOTS - 1)) begin
                    if (r_act == ACT_CLEAR) begin
                        n_held  = '0;
                        n_rec   = '0;
                        n_ok    = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_act   = i_action;
                    n_key   = i_key[KW-1:0];
                    n_val   = i_new_value[VW-1:0];
                    n_c     = '0;
                    n_sq    = '0;
                    n_ok    = 1'b0;
                    n_found = '0;
                    n_ins   = 1'b0;
                    mod_div = i_key_hash;
                    unique case (i_action) inside
                        ACT_INSERT: begin
                            // At capacity the bounded search runs first.
                            n_ins     = !(r_held >= r_cap);
                            mod_start = 1'b1;
                            n_state   = S_HASH;
                        end
                        ACT_REMOVE, ACT_SEARCH, ACT_GET: begin
                            mod_start = 1'b1;
                            n_state   = S_HASH;
                        end
                        ACT_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (mod_stat.done) begin
                    n_home  = mod_rem[SW-1:0];
                    n_slot  = mod_rem[SW-1:0];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_ins) begin
                    if (r_rd_valid && !key_eq) begin
                        if (r_c >= STEP_BITS'(PROBE_LIMIT)) begin
                            n_state = S_DONE;
                        end else begin
                            n_c       = r_c + 1'b1;
                            n_sq      = r_sq + QW'({r_c, 1'b1});
                            mod_start = 1'b1;
                            n_state   = S_STEP;
                        end
                    end else begin
                        we_val = 1'b1;
                        if (!r_rd_valid) begin
                            we_valid = 1'b1;
                            wd_valid = 1'b1;
                            we_key   = 1'b1;
                            n_held   = r_held + 1'b1;
                        end
                        if (r_c > STEP_BITS'(r_rec)) begin
                            n_rec = r_c[REC_BITS-1:0];
                        end
                        n_ok    = 1'b1;
                        n_state = S_DONE;
                    end
                end else if (r_rd_valid && !key_eq && within_rec) begin
                    n_c       = r_c + 1'b1;
                    n_sq      = r_sq + QW'({r_c, 1'b1});
                    mod_start = 1'b1;
                    n_state   = S_STEP;
                end else if (within_rec && r_rd_valid && key_eq) begin
                    case (r_act)
                        ACT_INSERT: begin
                            // Key present at capacity: rerun as an insert chain.
                            n_ins   = 1'b1;
                            n_slot  = r_home;
                            n_c     = '0;
                            n_sq    = '0;
                            n_state = S_READ;
                        end
                        ACT_REMOVE: begin
                            we_valid = 1'b1;
                            n_held   = r_held - 1'b1;
                            n_ok     = 1'b1;
                            n_state  = S_DONE;
                        end
                        ACT_GET: begin
                            n_found = r_rd_val;
                            n_ok    = 1'b1;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_ok    = 1'b1;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_state = S_DONE;
                end
            end
            S_STEP: begin
                if (mod_stat.done) begin
                    n_slot  = mod_rem[SW-1:0];
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_act       <= ACT_INSERT;
            r_sweep     <= '0;
            r_held      <= '0;
            r_rec       <= '0;
            r_out_valid <= 1'b0;
            r_bucket    <= CFG_BITS'(1021);
            r_cap       <= CFG_BITS'(785);
            r_offset    <= '0;
        end else begin
            r_state     <= n_state;
            r_act       <= n_act;
            r_sweep     <= n_sweep;
            r_held      <= n_held;
            r_rec       <= n_rec;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BUCKETS:  r_bucket <= i_cfg_data;
                    CFG_CAPACITY: r_cap    <= i_cfg_data;
                    CFG_OFFSET:   r_offset <= i_cfg_data[3:0];
                    default:      r_offset <= r_offset;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_val   <= n_val;
        r_home  <= n_home;
        r_slot  <= n_slot;
        r_c     <= n_c;
        r_sq    <= n_sq;
        r_ins   <= n_ins;
        r_ok    <= n_ok;
        r_found <= n_found;
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_found <= r_found;
            r_out_cnt   <= r_held;
            r_out_rec   <= r_rec;
        end
    end

    // Slot memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (we_valid) begin
            valid_mem[w_addr] <= wd_valid;
        end
        if (we_key) begin
            key_mem[w_addr] <= r_key;
        end
        if (we_val) begin
            value_mem[w_addr] <= r_val;
        end
        if (r_state == S_READ) begin
            r_rd_valid <= valid_mem[r_slot];
            r_rd_key   <= key_mem[r_slot];
            r_rd_val   <= value_mem[r_slot];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_found_value   = FIELD_BITS'(r_out_found);
    assign o_entry_count   = r_out_cnt;
    assign o_longest_probe = r_out_rec;

    // The entry count can never pass the number of slots.
    `OAH_ASSERT(a_held_bound, i_clk, i_rst_n, 32'(r_held) <= 32'(SLOTS))
    // The remainder unit finishes only while the sequencer waits for it.
    `OAH_ASSERT_IMP(a_mod_owner, i_clk, i_rst_n, mod_stat.done,
        (r_state == S_HASH) || (r_state == S_STEP))
    // While the sequencer waits for a remainder, the unit is working on it.
    `OAH_ASSERT_IMP(a_mod_busy, i_clk, i_rst_n,
        ((r_state == S_HASH) || (r_state == S_STEP)) && !mod_stat.done, mod_stat.busy)
    // An insert chain only ever raises the probe record.
    `OAH_ASSERT_IMP(a_rec_grows, i_clk, i_rst_n, (r_state == S_CMP) && r_ins,
        ##1 (r_rec >= $past(r_rec)))

endmodule

FILE: dv/oah_checker.sv
// Checker of the open-address hash table unit: watches the three channels, predicts each
// result word from its own copy of the table and compares. Depends on oah_pkg.
module oah_checker import oah_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [2:0]            i_action,
    input  logic [FIELD_BITS-1:0] i_key,
    input  logic [FIELD_BITS-1:0] i_key_hash,
    input  logic [FIELD_BITS-1:0] i_new_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_ok,
    input  logic [FIELD_BITS-1:0] i_found_value,
    input  logic [CNT_BITS-1:0]   i_entry_count,
    input  logic [REC_BITS-1:0]   i_longest_probe,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = DEF_SLOTS;
    localparam int PROBE_LIMIT = DEF_PROBE_LIMIT;

    typedef struct {
        logic                  ok;
        logic [FIELD_BITS-1:0] found_value;
        logic [CNT_BITS-1:0]   entry_count;
        logic [REC_BITS-1:0]   longest_probe;
    } t_table_reply;

    logic [CFG_BITS-1:0]   bucket_reg, capacity_reg;
    logic [3:0]            offset_reg;
    logic [FIELD_BITS-1:0] key_mem [SLOTS];
    logic [FIELD_BITS-1:0] value_mem [SLOTS];
    bit                    occupied [SLOTS];
    int unsigned           held;
    int unsigned           probe_rec;
    t_table_reply          replies_due [$];

    assign o_pending = replies_due.size();

    function automatic longint unsigned buckets_in_use();
        if (bucket_reg < 2) return 2;
        if (bucket_reg > SLOTS) return SLOTS;
        return bucket_reg;
    endfunction

    // Bounded search along the chain, no deeper than the probe record.
    function automatic bit locate_key(input logic [FIELD_BITS-1:0] k,
                                      input logic [FIELD_BITS-1:0] h,
                                      output longint unsigned where);
        longint unsigned b, slot, c;
        b = buckets_in_use();
        slot = h % b;
        c = 0;
        while (occupied[slot] && key_mem[slot] != k && c <= probe_rec) begin
            c++;
            slot = (slot + c * c + offset_reg) % b;
        end
        where = slot;
        return c <= probe_rec && occupied[slot] && key_mem[slot] == k;
    endfunction

    function automatic bit store_pair(input logic [FIELD_BITS-1:0] k,
                                      input logic [FIELD_BITS-1:0] h,
                                      input logic [FIELD_BITS-1:0] v);
        longint unsigned b, slot, c;
        b = buckets_in_use();
        c = 0;
        if (held >= capacity_reg && !locate_key(k, h, slot))
            return 0;
        slot = h % b;
        while (occupied[slot] && key_mem[slot] != k) begin
            if (c >= PROBE_LIMIT)
                return 0;
            c++;
            slot = (slot + c * c + offset_reg) % b;
        end
        if (!occupied[slot]) begin
            occupied[slot] = 1;
            key_mem[slot] = k;
            held++;
        end
        value_mem[slot] = v;
        if (c > probe_rec)
            probe_rec = c;
        return 1;
    endfunction

    function automatic t_table_reply apply_word(input logic [2:0] act,
                                                input logic [FIELD_BITS-1:0] k,
                                                input logic [FIELD_BITS-1:0] h,
                                                input logic [FIELD_BITS-1:0] v);
        t_table_reply    r;
        longint unsigned slot;
        r.ok = 0;
        r.found_value = '0;
        case (act)
            ACT_INSERT: r.ok = store_pair(k, h, v);
            ACT_REMOVE: begin
                if (held != 0 && locate_key(k, h, slot)) begin
                    occupied[slot] = 0;
                    held--;
                    r.ok = 1;
                end
            end
            ACT_SEARCH: r.ok = locate_key(k, h, slot);
            ACT_GET: begin
                if (locate_key(k, h, slot)) begin
                    r.ok = 1;
                    r.found_value = value_mem[slot];
                end
            end
            ACT_CLEAR: begin
                foreach (occupied[i]) occupied[i] = 0;
                held = 0;
                probe_rec = 0;
                r.ok = 1;
            end
            default: ;
        endcase
        r.entry_count = held[CNT_BITS-1:0];
        r.longest_probe = probe_rec[REC_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_table_reply exp_r;
        if (!i_rst_n) begin
            bucket_reg = 1021;
            capacity_reg = 785;
            offset_reg = 0;
            foreach (occupied[i]) occupied[i] = 0;
            held = 0;
            probe_rec = 0;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUCKETS:  bucket_reg = i_cfg_data;
                    CFG_CAPACITY: capacity_reg = i_cfg_data;
                    CFG_OFFSET:   offset_reg = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // The result register cannot hold the reply of a word taken at this same edge,
            // so the result is matched before the new word is predicted.
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    exp_r = replies_due.pop_front();
                    o_compared++;
                    if (i_ok !== exp_r.ok)
                        report_mismatch($sformatf("ok %b, expected %b", i_ok, exp_r.ok));
                    if (i_found_value !== exp_r.found_value)
                        report_mismatch($sformatf("found_value %h, expected %h",
                                                  i_found_value, exp_r.found_value));
                    if (i_entry_count !== exp_r.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  i_entry_count, exp_r.entry_count));
                    if (i_longest_probe !== exp_r.longest_probe)
                        report_mismatch($sformatf("longest_probe %0d, expected %0d",
                                                  i_longest_probe, exp_r.longest_probe));
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(apply_word(i_action, i_key, i_key_hash, i_new_value));
        end
    end

endmodule

FILE: dv/open_address_hash_table_unit_tb.sv
// Testbench top of the open-address hash table unit: clock, reset, stimulus and verdict.
// Depends on oah_pkg, the unit itself and the oah_checker module.
module open_address_hash_table_unit_tb import oah_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on any channel before the run is declared hung. The slowest
    // legal word is an insert at capacity with two chains of the full probe limit; a clear
    // takes one slot a cycle, and the reset sweep is the same length.
    localparam int HANG_LIMIT = 20000;

    logic                  i_clk = 0;
    logic                  i_rst_n;
    logic                  i_in_valid, o_in_ready;
    logic [2:0]            i_action;
    logic [FIELD_BITS-1:0] i_key, i_key_hash, i_new_value;
    logic                  o_out_valid, i_out_ready;
    logic                  o_ok;
    logic [FIELD_BITS-1:0] o_found_value;
    logic [CNT_BITS-1:0]   o_entry_count;
    logic [REC_BITS-1:0]   o_longest_probe;
    logic                  i_cfg_valid, o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_BITS-1:0]   i_cfg_data;

    int errors, pending, compared;
    int words_sent = 0;
    int cfg_writes = 0;
    int idle_run = 0;
    bit no_idle = 0;                 // set for a stretch where neither side idles
    bit crowd_hashes = 0;            // squeeze the hashes onto a few chains
    logic [FIELD_BITS-1:0] key_pool [40];

    always #5 i_clk = ~i_clk;

    open_address_hash_table_unit u_top (.*);

    oah_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action, .i_key, .i_key_hash, .i_new_value,
        .i_out_valid(o_out_valid), .i_out_ready, .i_ok(o_ok), .i_found_value(o_found_value),
        .i_entry_count(o_entry_count), .i_longest_probe(o_longest_probe),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_compared(compared)
    );

    // The receiver stalls on about one cycle in ten, except in the quiet stretch.
    always @(posedge i_clk)
        i_out_ready <= no_idle || ($urandom_range(99) >= 10);

    // Watchdog: counts cycles in which no word is taken on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= HANG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", HANG_LIMIT);
            $display("open_address_hash_table_unit verification failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // A fixed mix of the key gives every key the same hash while crowd_hashes is unchanged.
    function automatic logic [FIELD_BITS-1:0] hash_of(input logic [FIELD_BITS-1:0] k);
        logic [FIELD_BITS-1:0] h;
        h = k * 32'h9E37_79B1;
        h = h ^ (h >> 15);
        return crowd_hashes ? (h & 32'h3) : h;
    endfunction

    // Offers one word and returns at the edge where it was taken, with valid still high.
    task automatic send_word(input logic [2:0] act, input logic [FIELD_BITS-1:0] k,
                             input logic [FIELD_BITS-1:0] h, input logic [FIELD_BITS-1:0] v);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 10) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_action    <= act;
        i_key       <= k;
        i_key_hash  <= h;
        i_new_value <= v;
        // Ready only changes at a rising edge, so sampling it at the falling edge is safe.
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        words_sent++;
    endtask

    // Drops valid and waits until every outstanding result has been taken, plus a margin.
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Offers one register write and returns at the edge where it was taken.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_table(input int buckets, input int cap, input int offs);
        write_reg(CFG_BUCKETS, CFG_BITS'(buckets));
        write_reg(CFG_CAPACITY, CFG_BITS'(cap));
        write_reg(CFG_OFFSET, CFG_BITS'(offs));
        i_cfg_valid <= 0;
    endtask

    // One random word: mostly keys from a small pool so that lookups hit, some random keys,
    // hashes that occasionally disagree with the key, and a few undefined actions.
    task automatic random_word();
        int sel;
        logic [2:0] act;
        logic [FIELD_BITS-1:0] k, h;
        sel = $urandom_range(99);
        if (sel < 40)      act = ACT_INSERT;
        else if (sel < 55) act = ACT_REMOVE;
        else if (sel < 70) act = ACT_SEARCH;
        else if (sel < 95) act = ACT_GET;
        else if (sel < 97) act = ACT_CLEAR;
        else               act = 3'($urandom_range(7, 5));
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(39)] : $urandom;
        h = ($urandom_range(99) < 90) ? hash_of(k) : $urandom;
        send_word(act, k, h, $urandom);
    endtask

    task automatic random_phase(input int buckets, input int cap, input int offs,
                                input bit wipe, input int count);
        drain();
        set_table(buckets, cap, offs);
        if (wipe) send_word(ACT_CLEAR, 0, 0, 0);
        repeat (count) random_word();
    endtask

    initial begin
        i_rst_n     <= 0;
        i_in_valid  <= 0;
        i_action    <= ACT_INSERT;
        i_key       <= '0;
        i_key_hash  <= '0;
        i_new_value <= '0;
        i_cfg_valid <= 0;
        i_cfg_index <= CFG_BUCKETS;
        i_cfg_data  <= '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed words on the reset settings: extreme keys, hashes and values, every
        // action, removal from an empty table and undefined actions.
        send_word(ACT_REMOVE, 32'h1234, hash_of(32'h1234), 0);
        send_word(ACT_GET, '0, '0, '1);
        send_word(ACT_INSERT, '0, '0, '1);
        send_word(ACT_INSERT, '1, '1, '0);
        send_word(ACT_GET, '0, '0, 0);
        send_word(ACT_GET, '1, '1, 0);
        send_word(ACT_INSERT, '0, '0, 32'hA5A5_5A5A);
        send_word(ACT_GET, '0, '0, 0);
        // Three keys on one hash build a probe chain and raise the probe record.
        send_word(ACT_INSERT, 32'h11, '0, 32'h1);
        send_word(ACT_INSERT, 32'h22, '0, 32'h2);
        send_word(ACT_SEARCH, 32'h22, '0, 0);
        send_word(ACT_GET, 32'h22, '0, 0);
        send_word(ACT_SEARCH, 32'h33, '0, 0);
        send_word(ACT_REMOVE, 32'h11, '0, 0);
        send_word(ACT_GET, 32'h22, '0, 0);
        send_word(3'd5, '1, '1, '1);
        send_word(3'd6, 0, 0, 0);
        send_word(3'd7, '0, '1, '0);
        send_word(ACT_CLEAR, '1, '1, '1);
        send_word(ACT_REMOVE, '0, '0, 0);
        send_word(ACT_GET, '1, '1, 0);

        // Settings from the reset values out to both extremes, with and without wiping the
        // table first, so that stale entries meet a changed modulus.
        random_phase(1021, 785, 0, 0, 200);
        random_phase(2, 1, 8, 1, 150);
        random_phase(0, 0, 15, 0, 120);       // bucket count below range, capacity zero
        no_idle = 1;
        random_phase(2047, 2047, 0, 1, 200);  // bucket count above range
        no_idle = 0;
        random_phase(1024, 1024, 8, 0, 200);
        crowd_hashes = 1;
        random_phase(13, 9, 1, 1, 200);       // short cycles mean exhausted chains
        random_phase(2, 1024, 0, 1, 100);     // a two-slot table hits the probe limit
        random_phase(31, 20, 3, 1, 200);
        crowd_hashes = 0;
        random_phase(97, 64, 5, 0, 300);
        drain();

        $display("Sent %0d words over %0d register writes and compared %0d results.",
                 words_sent, cfg_writes, compared);
        $display("Covered extreme, out-of-range and crowded table settings with stalls.");
        if (errors == 0) begin
            $display("open_address_hash_table_unit verification clean");
        end else begin
            $display("open_address_hash_table_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/oah_pkg.sv
hdl/oah_mod.sv
hdl/open_address_hash_table_unit.sv
dv/oah_checker.sv
dv/open_address_hash_table_unit_tb.sv
